### rtl/core/mdc_pkg.sv
// Shared constants and types for the cofactor determinant block.
package mdc_pkg;
  localparam int MaxSize = 4;
  localparam int ElemW = 12;
  localparam int DetW = 50;
  localparam int CfgW = 3;
  localparam int IdxW = 4;
  localparam int CntW = 5;
  localparam int QDepth = 2;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [DetW-1:0] det_t;

  // One loaded matrix handed from the front to the back.
  typedef struct packed {
    logic [2:0] size;
    elem_t [15:0] m;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MINOR,
    BK_TOP,
    BK_DONE
  } bk_state_t;

  // Clamp the size register to 1..MaxSize.
  function automatic logic [2:0] eff_size(input logic [CfgW-1:0] s);
    logic [2:0] n;
    n = s;
    if (n == 3'd0) n = 3'd1;
    if (n > 3'(MaxSize)) n = 3'(MaxSize);
    return n;
  endfunction
endpackage

### rtl/core/matrix_determinant_cofactor.sv
// Top level: cofactor determinant with a loading front end and a compute back end.
// Elements are taken one per cycle, except that the last element of a matrix is
// held back while the two-deep matrix queue is full. The back end, built on one
// shared multiplier, takes a new matrix only once the last one's word is registered.
// Synchronous active-high reset; matrix_size resets to 4 and the load count to zero.
module matrix_determinant_cofactor import mdc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  elem_t           element_value,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CfgW-1:0] cfg_data,
  output logic            empty,
  input  logic            pop,
  output det_t            determinant_value
);
  logic fv, fr, bv, br;
  job_t fj, bj;

  assign cfg_ready = 1'b1;

  mdc_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .element_value(element_value),
    .cfg_wr(cfg_valid), .cfg_data(cfg_data),
    .job_valid(fv), .job_ready(fr), .job(fj)
  );
  mdc_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(fv), .in_ready(fr), .in_job(fj),
    .out_valid(bv), .out_ready(br), .out_job(bj)
  );
  mdc_back u_back (
    .clk(clk), .rst(rst), .job_valid(bv), .job_ready(br), .job(bj),
    .empty(empty), .pop(pop), .determinant_value(determinant_value)
  );
endmodule

### rtl/core/mdc_front.sv
// Front end: collects elements into a matrix and hands complete matrices on.
module mdc_front import mdc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  elem_t           element_value,
  input  logic            cfg_wr,
  input  logic [CfgW-1:0] cfg_data,
  output logic            job_valid,
  input  logic            job_ready,
  output job_t            job
);
  logic [CfgW-1:0] size_reg;
  logic [CntW-1:0] load_count;
  elem_t [15:0] mat;
  logic [2:0] n;
  logic [CntW-1:0] total;
  logic last;
  logic take;

  assign n = eff_size(size_reg);
  assign total = CntW'(n) * CntW'(n);
  assign last = (load_count + CntW'(1)) == total;
  // Holding the last element back while the queue is full keeps the matrix intact.
  assign full = last && !job_ready;
  assign take = push && !full;
  assign job_valid = take && last;
  always_comb begin
    job.size = n;
    job.m = mat;
    job.m[load_count[IdxW-1:0]] = element_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= CfgW'(MaxSize);
      load_count <= '0;
    end else if (cfg_wr) begin
      size_reg <= cfg_data;
      load_count <= '0;
    end else if (take) begin
      load_count <= last ? '0 : load_count + CntW'(1);
    end
    if (take) mat[load_count[IdxW-1:0]] <= element_value;
  end
endmodule

### rtl/core/mdc_queue.sv
// Short queue of loaded matrices between front and back.
module mdc_queue import mdc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);
  job_t slots [QDepth];
  logic wp, rp;
  logic [1:0] cnt;
  logic wr, rd;

  assign in_ready = cnt != 2'(QDepth);
  assign out_valid = cnt != 2'd0;
  assign out_job = slots[rp];
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
    if (wr) slots[wp] <= in_job;
  end
endmodule

### rtl/core/mdc_back.sv
// Back end: cofactor expansion on one shared multiplier, plus a result register.
module mdc_back import mdc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic empty,
  input  logic pop,
  output det_t determinant_value
);
  bk_state_t state, state_next;
  job_t cur;
  // 2x2 minors of the bottom rows, indexed by column pair; 3x3 minors by dropped column.
  logic signed [24:0] m2 [6];
  logic signed [37:0] m3 [4];
  logic [3:0] step, step_next;
  det_t acc, acc_next;
  logic signed [DetW-1:0] prod;
  logic signed [37:0] mul_b;
  elem_t mul_a;
  logic out_full;
  logic load_job;
  logic [2:0] n;
  logic [1:0] r2, r3;
  logic [1:0] ca [6];
  logic [1:0] cb [6];

  assign ca = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  assign cb = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
  assign n = cur.size;
  assign empty = !out_full;
  assign job_ready = state == BK_IDLE;
  assign load_job = job_valid && job_ready;
  // Row of the lower 2x2 minors and of the 3x3 row used.
  assign r2 = 2'(n - 3'd2);
  assign r3 = 2'(n - 3'd3);

  function automatic elem_t el(input job_t j, input logic [1:0] r, input logic [1:0] c);
    return j.m[4'(r) * 4'(j.size) + 4'(c)];
  endfunction

  function automatic logic [2:0] pidx(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] r;
    case ({a, b})
      4'b0001: r = 3'd0;
      4'b0010: r = 3'd1;
      4'b0011: r = 3'd2;
      4'b0110: r = 3'd3;
      4'b0111: r = 3'd4;
      4'b1011: r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // One multiply per cycle. Minor phase: steps 0..11 build the six 2x2 minors of
  // the bottom two rows (two products each). Top phase for n=4: four groups of four
  // steps, each building one 3x3 minor and adding its first-row term; for n=3, three steps.
  logic [2:0] pi;
  logic half;
  always_comb begin
    pi = step[3:1];
    half = step[0];
    mul_a = '0;
    mul_b = '0;
    if (pi < 3'd6) begin
      if (!half) begin
        mul_a = el(cur, r2, ca[pi]);
        mul_b = 38'(el(cur, 2'(r2 + 2'd1), cb[pi]));
      end else begin
        mul_a = el(cur, 2'(r2 + 2'd1), ca[pi]);
        mul_b = 38'(el(cur, r2, cb[pi]));
      end
    end
  end

  // 3x3 minor via three products, computed in the top phase sequencer.
  logic [1:0] tc, tj;
  logic [1:0] oc [3];
  logic [2:0] p_idx;
  logic signed [DetW-1:0] tprod;
  elem_t ta;
  logic signed [37:0] tb;
  logic [1:0] dropc;
  always_comb begin
    // step: [3:2] outer column (n=4), [1:0] inner index
    tc = step[3:2];
    tj = step[1:0];
    dropc = tc;
    oc[0] = (dropc == 2'd0) ? 2'd1 : 2'd0;
    oc[1] = (dropc <= 2'd1) ? 2'd2 : 2'd1;
    oc[2] = (dropc <= 2'd2) ? 2'd3 : 2'd2;
    ta = '0;
    tb = '0;
    p_idx = '0;
    if (n == 3'd4) begin
      if (tj < 2'd3) begin
        ta = el(cur, 2'd1, oc[tj]);
        // pair of the two remaining columns
        case (tj)
          2'd0: p_idx = pidx(oc[1], oc[2]);
          2'd1: p_idx = pidx(oc[0], oc[2]);
          2'd2: p_idx = pidx(oc[0], oc[1]);
          default: p_idx = '0;
        endcase
        tb = 38'(m2[p_idx]);
      end else begin
        ta = el(cur, 2'd0, tc);
        tb = m3[tc];
      end
    end else if (n == 3'd3) begin
      ta = el(cur, r3, tc);
      case (tc)
        2'd0: p_idx = 3'd3;
        2'd1: p_idx = 3'd1;
        default: p_idx = 3'd0;
      endcase
      tb = 38'(m2[p_idx]);
    end
  end

  // The minor phase and the top phase share the one multiplier.
  elem_t op_a;
  logic signed [37:0] op_b;
  assign op_a = (state == BK_TOP) ? ta : mul_a;
  assign op_b = (state == BK_TOP) ? tb : mul_b;
  assign prod = DetW'(op_a) * DetW'(op_b);
  assign tprod = prod;

  logic [1:0] m3_idx;
  logic m3_wr, m3_clr;
  always_comb begin
    state_next = state;
    step_next = step;
    acc_next = acc;
    m3_wr = 1'b0;
    m3_clr = 1'b0;
    m3_idx = tc;
    case (state)
      BK_IDLE: begin
        if (load_job) begin
          state_next = BK_MINOR;
          step_next = '0;
        end
      end
      BK_MINOR: begin
        if (n == 3'd1) begin
          acc_next = DetW'(el(cur, 2'd0, 2'd0));
          state_next = BK_DONE;
        end else if (n == 3'd2) begin
          // only pair 0 matters
          if (step == 4'd1) begin
            acc_next = DetW'(m2[0]) - prod;
            state_next = BK_DONE;
          end
          step_next = step + 4'd1;
        end else begin
          if (step == 4'd11) begin
            state_next = BK_TOP;
            step_next = '0;
            acc_next = '0;
            m3_clr = 1'b1;
          end else begin
            step_next = step + 4'd1;
          end
        end
      end
      BK_TOP: begin
        if (n == 3'd3) begin
          // alternating signs on the first row
          if (tc == 2'd1) acc_next = acc - tprod;
          else acc_next = acc + tprod;
          if (tc == 2'd2) state_next = BK_DONE;
          else step_next = {step[3:2] + 2'd1, 2'b00};
          // tc walks via step[3:2]
          step_next[1:0] = 2'b00;
        end else begin
          if (tj < 2'd3) begin
            m3_wr = 1'b1;
          end else begin
            if (tc[0]) acc_next = acc - tprod;
            else acc_next = acc + tprod;
            if (tc == 2'd3) state_next = BK_DONE;
          end
          step_next = step + 4'd1;
        end
      end
      BK_DONE: begin
        if (!out_full || pop) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_DONE && (!out_full || pop)) out_full <= 1'b1;
      else if (pop && out_full) out_full <= 1'b0;
    end
    step <= step_next;
    acc <= acc_next;
    if (load_job) cur <= job;
    if (state == BK_DONE && (!out_full || pop)) determinant_value <= acc;
    if (state == BK_MINOR && pi < 3'd6) begin
      if (!half) m2[pi] <= 25'(prod);
      else m2[pi] <= m2[pi] - 25'(prod);
    end
    if (m3_clr) begin
      for (int i = 0; i < 4; i++) m3[i] <= '0;
    end else if (m3_wr) begin
      if (tj == 2'd1) m3[m3_idx] <= m3[m3_idx] - 38'(tprod);
      else m3[m3_idx] <= m3[m3_idx] + 38'(tprod);
    end
  end
endmodule
